/* rtl/gmin_pkg.sv */
// Package: shared constants and types for the greedy node-order block.
`timescale 1ns / 1ps
package gmin_pkg;
  localparam int DefMaxNodes = 64;
  localparam int DefMaxEdges = 256;
  localparam int DefWeightBits = 20;
  localparam int ArcModulus = 100000;

  typedef enum logic [0:0] {
    CMD_LOAD    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SUM_RD,
    ST_SUM_NODE,
    ST_SUM_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT,
    ST_UPD_RD,
    ST_UPD_DIV,
    ST_UPD_MOD,
    ST_UPD_WR,
    ST_DONE
  } back_state_t;

  // Queue entry passed from the front part to the back part.
  typedef struct packed {
    logic       compute;
    logic [5:0] src;
    logic [5:0] dst;
    logic [19:0] wt;
  } req_t;
endpackage

/* rtl/greedy_min_inweight_node_order.sv */
// Top level of the greedy minimum-in-weight node ordering block.
`timescale 1ns / 1ps
// Edge load requests pass through a two-entry queue and are stored one per
// cycle while the back part is idle, so loads may arrive back to back. A compute
// request is accepted, then the node tables are cleared and incoming weights are
// summed over the stored edges (edge read, node read, node write). Each removed
// node then costs a scan over all nodes, a step to mark it, the result being
// presented until the receiver takes it, and a walk over the edge store to apply
// decrements (edge read, quotient, remainder with node read, node write). A last
// step empties the store.
// No further request is taken from the queue until the compute has finished.
// Results leave on the m_axis side: tdata holds node_index and edges_dropped,
// tlast marks the final node. After each compute the edge store empties.
module greedy_min_inweight_node_order #(
  parameter int MAX_NODES   = gmin_pkg::DefMaxNodes,
  parameter int MAX_EDGES   = gmin_pkg::DefMaxEdges,
  parameter int WEIGHT_BITS = gmin_pkg::DefWeightBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // source_node, target_node, edge_weight
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // node_index, edges_dropped, zero pad
  output logic        m_axis_tlast   // last
);
  import gmin_pkg::*;

  logic [6:0] node_count;
  req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [5:0] o_node;
  logic o_drop;

  always_ff @(posedge clk) begin
    if (rst) node_count <= '0;
    else if (cfg_we) node_count <= cfg_wdata;
  end

  assign in_req.compute = s_axis_tuser;
  assign in_req.src = s_axis_tdata[5:0];
  assign in_req.dst = s_axis_tdata[11:6];
  assign in_req.wt  = s_axis_tdata[31:12];

  gmin_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  gmin_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS))
  u_back (
    .clk(clk), .rst(rst), .node_count(node_count), .q_valid(q_valid),
    .q_ready(q_ready), .q_req(q_req), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_node(o_node), .out_last(m_axis_tlast),
    .out_drop(o_drop)
  );

  assign m_axis_tdata = {1'b0, o_drop, o_node};
endmodule

/* rtl/gmin_front.sv */
// Front part: accepts requests and holds them in a short queue.
`timescale 1ns / 1ps
module gmin_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gmin_pkg::req_t in_req,
  output logic           q_valid,
  input  logic           q_ready,
  output gmin_pkg::req_t q_req
);
  import gmin_pkg::*;

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_pop: assert property (@(posedge clk) disable iff (rst) pop |-> fill != 2'd0)
    else $error("pop from empty queue");
  a_push: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !push) else $error("push into full queue");
`endif
endmodule

/* rtl/gmin_back.sv */
// Back part: edge store, node tables and the greedy ordering sequencer.
`timescale 1ns / 1ps
module gmin_back #(
  parameter int MAX_NODES   = gmin_pkg::DefMaxNodes,
  parameter int MAX_EDGES   = gmin_pkg::DefMaxEdges,
  parameter int WEIGHT_BITS = gmin_pkg::DefWeightBits
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [6:0]     node_count,
  input  logic           q_valid,
  output logic           q_ready,
  input  gmin_pkg::req_t q_req,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [5:0]     out_node,
  output logic           out_last,
  output logic           out_drop
);
  import gmin_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int EB = $clog2(MAX_EDGES);
  localparam int NW = WEIGHT_BITS + EB;
  localparam int SB = $clog2(MAX_NODES + MAX_EDGES * MAX_NODES + 1);
  localparam int MB = $clog2(ArcModulus);
  // The modulus is 32 * 3125. The quotient by 3125 of a 26-bit value is the
  // top bits of its product with the rounded-up reciprocal scaled by 2^38.
  localparam int RecipShift = 38;
  localparam logic [26:0] RecipMul = 27'd87960931;

  // Edge store memory.
  logic [NB-1:0]          e_from [MAX_EDGES];
  logic [NB-1:0]          e_to   [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] e_wt   [MAX_EDGES];
  logic [NB-1:0]          rd_from, rd_to;
  logic [WEIGHT_BITS-1:0] rd_wt;
  logic                   e_rd_en;
  // Node tables memory (one port read, one write).
  logic [NW-1:0]          n_wt  [MAX_NODES];
  logic [SB-1:0]          n_st  [MAX_NODES];
  logic [NW-1:0]          rn_wt;
  logic [SB-1:0]          rn_st;
  logic [MAX_NODES-1:0]   removed;

  back_state_t state, state_next;
  logic [EB:0]  edges_loaded;
  logic         drop_seen;
  logic [SB-1:0] stamp;
  logic [NB:0]  n;
  logic [NB:0]  idx;
  logic [EB:0]  eidx;
  logic [NB:0]  k;
  logic [NB-1:0] best;
  logic [NW-1:0] best_w;
  logic [SB-1:0] best_s;
  logic          found;
  logic [NB-1:0] scan_node;
  logic [MB-1:0] dec;
  logic [25:0]   div_in;
  logic [52:0]   div_prod;
  logic [14:0]   quot;
  logic [NB:0]   n_cnt;
  logic [NB-1:0] n_rd_addr;
  logic          n_wr_en;
  logic [NB-1:0] n_wr_addr;
  logic [NW-1:0] n_wr_wt;
  logic [SB-1:0] n_wr_st;
  logic          load_ok;

  assign n_cnt = (int'(node_count) > MAX_NODES) ? (NB+1)'(MAX_NODES) : (NB+1)'(node_count);
  assign load_ok = (int'(q_req.src) < int'(n_cnt))
                && (int'(q_req.dst) < int'(n_cnt))
                && (edges_loaded < (EB+1)'(MAX_EDGES));
  assign q_ready = (state == ST_IDLE);

  // The edge read register holds its entry while the node side is worked on.
  assign e_rd_en = (state == ST_SUM_RD) || (state == ST_UPD_RD);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_req.compute == CMD_LOAD && load_ok) begin
      e_from[edges_loaded[EB-1:0]] <= NB'(q_req.src);
      e_to[edges_loaded[EB-1:0]]   <= NB'(q_req.dst);
      e_wt[edges_loaded[EB-1:0]]   <= WEIGHT_BITS'(q_req.wt);
    end
    if (e_rd_en) begin
      rd_from <= e_from[eidx[EB-1:0]];
      rd_to   <= e_to[eidx[EB-1:0]];
      rd_wt   <= e_wt[eidx[EB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr_en) begin
      n_wt[n_wr_addr] <= n_wr_wt;
      n_st[n_wr_addr] <= n_wr_st;
    end
    rn_wt <= n_wt[n_rd_addr];
    rn_st <= n_st[n_rd_addr];
  end

  always_comb begin
    n_wr_en = 1'b0;
    n_wr_addr = idx[NB-1:0];
    n_wr_wt = '0;
    n_wr_st = SB'(idx);
    n_rd_addr = idx[NB-1:0];
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_req.compute == CMD_COMPUTE) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (idx < n) n_wr_en = 1'b1;
        else state_next = ST_SUM_RD;
      end
      ST_SUM_RD: begin
        if (eidx < edges_loaded) state_next = ST_SUM_NODE;
        else if (n == '0) state_next = ST_DONE;
        else state_next = ST_SCAN;
      end
      ST_SUM_NODE: begin
        n_rd_addr = rd_to;
        state_next = ST_SUM_WR;
      end
      ST_SUM_WR: begin
        n_wr_addr = rd_to;
        n_wr_wt = rn_wt + NW'(rd_wt);
        n_wr_st = rn_st;
        n_wr_en = ({1'b0, rd_from} < n) && ({1'b0, rd_to} < n);
        state_next = ST_SUM_RD;
      end
      ST_SCAN: begin
        n_rd_addr = idx[NB-1:0];
        if (idx == n) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_EMIT;
      ST_EMIT: if (out_ready) state_next = ST_UPD_RD;
      ST_UPD_RD: begin
        if (eidx < edges_loaded) state_next = ST_UPD_DIV;
        else if (k == n) state_next = ST_DONE;
        else state_next = ST_SCAN;
      end
      ST_UPD_DIV: state_next = ST_UPD_MOD;
      ST_UPD_MOD: begin
        n_rd_addr = rd_to;
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        n_wr_addr = rd_to;
        n_wr_wt = (rn_wt >= NW'(dec)) ? rn_wt - NW'(dec) : '0;
        n_wr_st = stamp;
        n_wr_en = (rd_from == best) && ({1'b0, rd_to} < n) && !removed[rd_to];
        state_next = ST_UPD_RD;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Scan compares the node read in the previous cycle.
  assign scan_node = NB'(idx - 1'b1);
  assign div_in = 26'(rd_wt >> 5);
  assign div_prod = {27'b0, div_in} * {26'b0, RecipMul};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      edges_loaded <= '0;
      drop_seen <= 1'b0;
      removed <= '0;
      idx <= '0;
      eidx <= '0;
      k <= '0;
      found <= 1'b0;
      stamp <= '0;
      n <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          eidx <= '0;
          if (q_valid && q_req.compute == CMD_LOAD) begin
            if (load_ok) edges_loaded <= edges_loaded + 1'b1;
            else drop_seen <= 1'b1;
          end
          if (q_valid && q_req.compute == CMD_COMPUTE) begin
            n <= n_cnt;
            stamp <= SB'(n_cnt);
            k <= '0;
          end
        end
        ST_INIT: begin
          if (idx < n) begin
            removed[idx[NB-1:0]] <= 1'b0;
            idx <= idx + 1'b1;
          end
        end
        ST_SUM_RD: begin
          idx <= '0;
          found <= 1'b0;
          if (eidx < edges_loaded) eidx <= eidx + 1'b1;
          else eidx <= '0;
        end
        ST_SUM_WR: ;
        ST_SCAN: begin
          if (idx != '0 && !removed[scan_node] &&
              (!found || rn_wt < best_w || (rn_wt == best_w && rn_st < best_s))) begin
            best <= scan_node; best_w <= rn_wt; best_s <= rn_st; found <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        ST_SCAN_END: begin
          removed[best] <= 1'b1;
          k <= k + 1'b1;
          eidx <= '0;
        end
        ST_EMIT: ;
        ST_UPD_RD: begin
          idx <= '0;
          found <= 1'b0;
          if (eidx < edges_loaded) eidx <= eidx + 1'b1;
          else eidx <= '0;
        end
        ST_UPD_DIV: begin
          quot <= div_prod[52:RecipShift];
        end
        ST_UPD_MOD: begin
          // Remainder of the edge weight after taking out whole moduli.
          dec <= MB'(32'(rd_wt) - 32'(quot) * ArcModulus);
        end
        ST_UPD_WR: if (n_wr_en) stamp <= stamp + 1'b1;
        ST_DONE: begin
          edges_loaded <= '0;
          drop_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_EMIT);
  assign out_node  = 6'(best);
  assign out_last  = (k == n);
  assign out_drop  = drop_seen;

`ifndef ASSERT_OFF
  a_emit_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> removed[best]) else $error("emitted node not marked removed");
  a_k_range: assert property (@(posedge clk) disable iff (rst) k <= n)
    else $error("emit count past node count");
  a_store: assert property (@(posedge clk) disable iff (rst)
    edges_loaded <= (EB+1)'(MAX_EDGES)) else $error("edge store overfilled");
`endif
endmodule
